// ===== hw/rtl/ftv_pkg.sv =====
// ----------------------------------------------------------------------------
// FIX tag=value parser package
// Shared constants, record types and the tag class lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package ftv_pkg;

	localparam int SEEN_TAGS     = 2048;
	localparam int SEEN_AW       = $clog2(SEEN_TAGS);
	localparam int MAX_MSG_BYTES = 4096;
	localparam int POS_W         = $clog2(MAX_MSG_BYTES);
	localparam int EPOCH_W       = 8;
	localparam int TAG_W         = 24;
	localparam int SEQ_W         = 31;
	localparam int CNT_W         = 11;
	localparam int CLS_W         = 4;
	localparam int QDEPTH        = 4;
	localparam int QAW           = $clog2(QDEPTH);

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_MSG_BYTES - 1);
	localparam logic [TAG_W-1:0] TAG_MAX = {TAG_W{1'b1}};
	localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_EQ  = 8'h3D;
	localparam logic [7:0] CH_Y   = 8'h59;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_9   = 8'h39;

	localparam logic [CLS_W-1:0] CLS_OTHER     = 4'd0;
	localparam logic [CLS_W-1:0] CLS_MSGTYPE   = 4'd1;
	localparam logic [CLS_W-1:0] CLS_SEQNUM    = 4'd2;
	localparam logic [CLS_W-1:0] CLS_POSSDUP   = 4'd3;
	localparam logic [CLS_W-1:0] CLS_POSSRES   = 4'd4;
	localparam logic [CLS_W-1:0] CLS_SNDCOMP   = 4'd5;
	localparam logic [CLS_W-1:0] CLS_TGTCOMP   = 4'd6;
	localparam logic [CLS_W-1:0] CLS_SNDSUB    = 4'd7;
	localparam logic [CLS_W-1:0] CLS_TGTSUB    = 4'd8;
	localparam logic [CLS_W-1:0] CLS_SENDTIME  = 4'd9;
	localparam logic [CLS_W-1:0] CLS_ORIGTIME  = 4'd10;
	localparam logic [CLS_W-1:0] CLS_CHECKSUM  = 4'd11;
	localparam logic [CLS_W-1:0] CLS_BEGINSTR  = 4'd12;
	localparam logic [CLS_W-1:0] CLS_BODYLEN   = 4'd13;

	// Request from the parser to the seen-tag store.
	typedef struct packed {
		logic [SEEN_AW-1:0] rd_addr;
		logic               mark;
		logic [SEEN_AW-1:0] mark_addr;
		logic               msg_end;
	} ftv_seen_req_t;

	typedef struct packed {
		logic hit;
		logic busy;
	} ftv_seen_rsp_t;

	// One queue entry: everything one byte produces (a field record, a summary, or both).
	typedef struct packed {
		logic             has_field;
		logic             has_sum;
		logic [TAG_W-1:0] tag;
		logic [CLS_W-1:0] cls;
		logic [POS_W-1:0] off;
		logic [POS_W-1:0] len;
		logic [SEQ_W-1:0] seq;
		logic             pd;
		logic             pr;
		logic             dup;
		logic             cks;
		logic [CNT_W-1:0] cnt;
	} ftv_entry_t;

	function automatic logic [CLS_W-1:0] class_of(input logic [TAG_W-1:0] t);
		logic [CLS_W-1:0] c;
		case (t)
			TAG_W'(35):  c = CLS_MSGTYPE;
			TAG_W'(34):  c = CLS_SEQNUM;
			TAG_W'(43):  c = CLS_POSSDUP;
			TAG_W'(97):  c = CLS_POSSRES;
			TAG_W'(49):  c = CLS_SNDCOMP;
			TAG_W'(56):  c = CLS_TGTCOMP;
			TAG_W'(50):  c = CLS_SNDSUB;
			TAG_W'(57):  c = CLS_TGTSUB;
			TAG_W'(52):  c = CLS_SENDTIME;
			TAG_W'(122): c = CLS_ORIGTIME;
			TAG_W'(10):  c = CLS_CHECKSUM;
			TAG_W'(8):   c = CLS_BEGINSTR;
			TAG_W'(9):   c = CLS_BODYLEN;
			default:     c = CLS_OTHER;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ftv_seen.sv =====
// ----------------------------------------------------------------------------
// Seen-tag store
// Per-tag message marks in a memory, with a message epoch so that no
// per-message clear is needed; a full clearing pass runs after reset and
// whenever the epoch wraps.
// ----------------------------------------------------------------------------
`default_nettype none

module ftv_seen import ftv_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ftv_seen_req_t req,
	output ftv_seen_rsp_t      rsp
);

	logic [EPOCH_W-1:0] mem [SEEN_TAGS];
	logic [EPOCH_W-1:0] rd_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic               clr_q;
	logic [SEEN_AW-1:0] clr_cnt_q;
	logic               byp_q;

	logic               we;
	logic [SEEN_AW-1:0] waddr;
	logic [EPOCH_W-1:0] wdata;

	assign we    = clr_q || req.mark;
	assign waddr = clr_q ? clr_cnt_q : req.mark_addr;
	assign wdata = clr_q ? '0 : epoch_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[req.rd_addr];
	end

	// A mark written at the same edge as the read is seen through the bypass bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q   <= EPOCH_W'(1);
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			byp_q     <= 1'b0;
		end else begin
			byp_q <= req.mark && (req.mark_addr == req.rd_addr) && !req.msg_end;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + SEEN_AW'(1);
				if (clr_cnt_q == SEEN_AW'(SEEN_TAGS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (req.msg_end) begin
				if (epoch_q == {EPOCH_W{1'b1}}) begin
					epoch_q   <= EPOCH_W'(1);
					clr_q     <= 1'b1;
					clr_cnt_q <= '0;
				end else begin
					epoch_q <= epoch_q + EPOCH_W'(1);
				end
			end
		end
	end

	assign rsp.hit  = (rd_q == epoch_q) || byp_q;
	assign rsp.busy = clr_q;

`ifndef SYNTHESIS
	a_epoch_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_q != '0) else $error("epoch reached zero");
	a_no_mark_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !req.mark) else $error("tag marked during clearing pass");
	a_clear_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(clr_q && clr_cnt_q == SEEN_AW'(SEEN_TAGS - 1) && !req.msg_end) |=> !clr_q)
		else $error("clearing pass did not end");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/ftv_front.sv =====
// ----------------------------------------------------------------------------
// Parser front end
// Accepts one byte a cycle while accept is high, tracks tag and value
// phases and builds the record entry for each byte ending a field or message.
// ----------------------------------------------------------------------------
`default_nettype none

module ftv_front import ftv_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    msg_byte,
	input  wire logic          end_of_msg,
	input  wire ftv_seen_rsp_t seen_rsp,
	output ftv_seen_req_t      seen_req,
	output logic               ent_push,
	output ftv_entry_t         ent
);

	typedef enum logic [1:0] {
		PH_TAG,
		PH_VALUE,
		PH_STOP
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [TAG_W-1:0] tag_q, tag_d;
	logic             tdo_q, tdo_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0] vstart_q, vstart_d;
	logic [CLS_W-1:0] cls_q, cls_d;
	logic [SEQ_W-1:0] seq_q, seq_d;
	logic             vdo_q, vdo_d;
	logic [3:0]       flags_q, flags_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	logic             is_digit;
	logic [3:0]       digit;
	logic [TAG_W+3:0] tag_x10;
	logic [SEQ_W+3:0] seq_x10;
	logic             tag_small;
	logic             rec;
	logic [POS_W-1:0] rec_len;
	logic [POS_W:0]   pos_p1;
	logic [CLS_W-1:0] new_cls;

	assign is_digit  = (msg_byte >= CH_0) && (msg_byte <= CH_9);
	assign digit     = 4'(msg_byte - CH_0);
	assign tag_x10   = {4'b0, tag_q} * (TAG_W + 4)'(10) + (TAG_W + 4)'(digit);
	assign seq_x10   = {4'b0, seq_q} * (SEQ_W + 4)'(10) + (SEQ_W + 4)'(digit);
	assign tag_small = tag_q < TAG_W'(SEEN_TAGS);
	assign pos_p1    = {1'b0, pos_q} + (POS_W + 1)'(1);
	assign new_cls   = class_of(tag_q);

	always_comb begin
		phase_d  = phase_q;
		tag_d    = tag_q;
		tdo_d    = tdo_q;
		pos_d    = pos_q;
		vstart_d = vstart_q;
		cls_d    = cls_q;
		seq_d    = seq_q;
		vdo_d    = vdo_q;
		flags_d  = flags_q;
		cnt_d    = cnt_q;
		rec      = 1'b0;
		rec_len  = '0;
		seen_req.mark      = 1'b0;
		seen_req.mark_addr = tag_q[SEEN_AW-1:0];
		if (accept) begin
			case (phase_q)
				PH_TAG: begin
					if (msg_byte == CH_EQ) begin
						if (tag_small && seen_rsp.hit) begin
							flags_d[2] = 1'b1;
							phase_d    = PH_STOP;
						end else begin
							seen_req.mark = tag_small;
							cls_d    = new_cls;
							vstart_d = (pos_q == POS_MAX) ? POS_MAX : pos_p1[POS_W-1:0];
							if (new_cls == CLS_SEQNUM) begin
								seq_d = '0;
								vdo_d = 1'b1;
							end else if (new_cls == CLS_CHECKSUM) begin
								flags_d[3] = 1'b1;
							end
							phase_d = PH_VALUE;
						end
					end else if (msg_byte == CH_SOH) begin
						phase_d = PH_STOP;
					end else if (tdo_q && is_digit) begin
						tag_d = (tag_x10 > (TAG_W + 4)'(TAG_MAX)) ? TAG_MAX : tag_x10[TAG_W-1:0];
					end else begin
						tdo_d = 1'b0;
					end
				end
				PH_VALUE: begin
					if (msg_byte == CH_SOH) begin
						rec     = 1'b1;
						rec_len = (pos_q >= vstart_q) ? pos_q - vstart_q : '0;
						phase_d = PH_TAG;
						tag_d   = '0;
						tdo_d   = 1'b1;
						cls_d   = CLS_OTHER;
					end else begin
						if (pos_q == vstart_q && msg_byte == CH_Y) begin
							if (cls_q == CLS_POSSDUP) flags_d[0] = 1'b1;
							if (cls_q == CLS_POSSRES) flags_d[1] = 1'b1;
						end
						if (cls_q == CLS_SEQNUM) begin
							if (vdo_q && is_digit) begin
								seq_d = (seq_x10 > (SEQ_W + 4)'(SEQ_MAX)) ?
									SEQ_MAX : seq_x10[SEQ_W-1:0];
							end else begin
								vdo_d = 1'b0;
							end
						end
						if (end_of_msg) begin
							rec     = 1'b1;
							rec_len = (pos_p1 >= {1'b0, vstart_q}) ?
								POS_W'(pos_p1 - {1'b0, vstart_q}) : '0;
						end
					end
				end
				default: begin
				end
			endcase
			if (rec && cnt_q != CNT_MAX) begin
				cnt_d = cnt_q + CNT_W'(1);
			end
			if (pos_q != POS_MAX) begin
				pos_d = pos_p1[POS_W-1:0];
			end
		end
		// The store reads the entry for the tag as this byte leaves it.
		seen_req.msg_end = accept && end_of_msg;
		seen_req.rd_addr = (accept && end_of_msg) ? '0 : tag_d[SEEN_AW-1:0];
	end

	// The summary reads the state as this byte leaves it.
	always_comb begin
		ent.has_field = rec;
		ent.has_sum   = end_of_msg;
		ent.tag       = rec ? tag_q : (flags_d[2] ? tag_d : '0);
		ent.cls       = cls_q;
		ent.off       = vstart_q;
		ent.len       = rec_len;
		ent.seq       = seq_d;
		ent.pd        = flags_d[0];
		ent.pr        = flags_d[1];
		ent.dup       = flags_d[2];
		ent.cks       = flags_d[3];
		ent.cnt       = cnt_d;
	end

	assign ent_push = accept && (rec || end_of_msg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TAG;
			tag_q    <= '0;
			tdo_q    <= 1'b1;
			pos_q    <= '0;
			vstart_q <= '0;
			cls_q    <= CLS_OTHER;
			seq_q    <= '0;
			vdo_q    <= 1'b1;
			flags_q  <= '0;
			cnt_q    <= '0;
		end else if (accept && end_of_msg) begin
			phase_q  <= PH_TAG;
			tag_q    <= '0;
			tdo_q    <= 1'b1;
			pos_q    <= '0;
			vstart_q <= '0;
			cls_q    <= CLS_OTHER;
			seq_q    <= '0;
			vdo_q    <= 1'b1;
			flags_q  <= '0;
			cnt_q    <= '0;
		end else begin
			phase_q  <= phase_d;
			tag_q    <= tag_d;
			tdo_q    <= tdo_d;
			pos_q    <= pos_d;
			vstart_q <= vstart_d;
			cls_q    <= cls_d;
			seq_q    <= seq_d;
			vdo_q    <= vdo_d;
			flags_q  <= flags_d;
			cnt_q    <= cnt_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ftv_queue.sv =====
// ----------------------------------------------------------------------------
// Record queue and output sequencer
// Holds parser entries and hands out their field record and summary
// record one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module ftv_queue import ftv_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire ftv_entry_t din,
	output logic            q_full,
	input  wire logic       pop,
	output logic            empty,
	output logic            rec_kind,
	output logic            last_of_run,
	output ftv_entry_t      head
);

	ftv_entry_t     ent_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;
	logic           fdone_q;
	logic           show_field;
	logic           take;
	logic           retire;

	assign q_full     = cnt_q == (QAW + 1)'(QDEPTH);
	assign empty      = cnt_q == '0;
	assign head       = ent_q[rd_ptr_q];
	assign show_field = head.has_field && !fdone_q;
	assign rec_kind   = !show_field;
	assign last_of_run = !(show_field && head.has_sum);
	assign take       = pop && !empty;
	assign retire     = take && last_of_run;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			fdone_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (retire) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
				fdone_q  <= 1'b0;
			end else if (take) begin
				fdone_q <= 1'b1;
			end
			cnt_q <= cnt_q + (QAW + 1)'(push) - (QAW + 1)'(retire);
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QAW + 1)'(QDEPTH)) else $error("queue count overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full)) else $error("push into full queue");
	a_fdone_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !fdone_q) else $error("half-sent entry in empty queue");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/fix_tag_value_field_parser_top.sv =====
// ----------------------------------------------------------------------------
// FIX tag=value field parser
// Byte-serial FIX message parser emitting field records and a per-message
// summary through queue-style handshakes.
// ----------------------------------------------------------------------------
// The parser takes one message byte per clock cycle (push while full is low)
// and decodes SOH-delimited tag=value fields. Every completed field produces
// a field record (tag, class, value offset and length); the byte flagged with
// end_of_msg also produces a summary record carrying the sequence number,
// PossDup and PossResend flags, the duplicate-tag status, whether a CheckSum
// field was seen and the field count. Records come out oldest first while
// empty is low and leave on pop; last_of_run marks the final record caused by
// one byte. A front end parses each byte and in the same cycle writes an entry
// into a four-deep queue; the back end reads one record per cycle from it, so
// the input runs at one byte per cycle as long as records are drained, and a
// byte that yields both a field record and a summary hands out the field
// record first. Repeated-tag detection uses a 2048-entry memory stamped with a
// message epoch. After reset, and again after every 255th message when the
// epoch wraps, the memory is swept clear, during which full stays high.
// ----------------------------------------------------------------------------
`default_nettype none

module fix_tag_value_field_parser_top import ftv_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [7:0]       msg_byte,
	input  wire logic             end_of_msg,
	output logic                  empty,
	input  wire logic             pop,
	output logic                  rec_kind,
	output logic [TAG_W-1:0]      tag_number,
	output logic [CLS_W-1:0]      field_class,
	output logic [POS_W-1:0]      value_offset,
	output logic [POS_W-1:0]      value_length,
	output logic [SEQ_W-1:0]      seq_number,
	output logic                  poss_dup,
	output logic                  poss_resend,
	output logic                  dup_found,
	output logic                  checksum_seen,
	output logic [CNT_W-1:0]      field_count,
	output logic                  last_of_run
);

	ftv_seen_req_t seen_req;
	ftv_seen_rsp_t seen_rsp;
	ftv_entry_t    ent;
	ftv_entry_t    head;
	logic          ent_push;
	logic          q_full;
	logic          accept;

	// A byte is taken only when the queue has room and the seen-tag store is ready.
	assign full   = q_full || seen_rsp.busy;
	assign accept = push && !full;

	ftv_seen u_seen (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (seen_req),
		.rsp    (seen_rsp)
	);

	ftv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.msg_byte   (msg_byte),
		.end_of_msg (end_of_msg),
		.seen_rsp   (seen_rsp),
		.seen_req   (seen_req),
		.ent_push   (ent_push),
		.ent        (ent)
	);

	ftv_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (ent_push),
		.din         (ent),
		.q_full      (q_full),
		.pop         (pop),
		.empty       (empty),
		.rec_kind    (rec_kind),
		.last_of_run (last_of_run),
		.head        (head)
	);

	// Field records carry the field part of the entry and zeros elsewhere;
	// summaries the reverse, but a summary with dup_found set carries the repeated tag.
	always_comb begin
		tag_number    = head.tag;
		field_class   = rec_kind ? CLS_OTHER : head.cls;
		value_offset  = rec_kind ? '0 : head.off;
		value_length  = rec_kind ? '0 : head.len;
		seq_number    = rec_kind ? head.seq : '0;
		poss_dup      = rec_kind && head.pd;
		poss_resend   = rec_kind && head.pr;
		dup_found     = rec_kind && head.dup;
		checksum_seen = rec_kind && head.cks;
		field_count   = rec_kind ? head.cnt : '0;
		if (rec_kind && !head.dup) begin
			tag_number = '0;
		end
	end

endmodule

`default_nettype wire
